### hdl/sdiowf_pkg.sv
// sdiowf_pkg: request codes, card address map, enumeration rom and the card byte read function
// used by sdio_wifi_card_register_model; no dependencies
package sdiowf_pkg;

  typedef enum logic [3:0] {
    ReqReadResp   = 4'd0,
    ReqReadBuffer = 4'd1,
    ReqReadClkCtl = 4'd2,
    ReqReadFlags  = 4'd3,
    ReqReadEnable = 4'd4,
    ReqWriteArgs  = 4'd5,
    ReqWriteCmd   = 4'd6,
    ReqWriteClk   = 4'd7,
    ReqClearFlags = 4'd8,
    ReqWriteEn    = 4'd9
  } req_e;

  localparam logic [5:0] CmdIoSendOpCond = 6'd5;
  localparam logic [5:0] CmdSelect       = 6'd7;
  localparam logic [5:0] CmdIoRwDirect   = 6'd52;
  localparam logic [5:0] CmdIoRwExtended = 6'd53;

  localparam logic [31:0] RespOpCond = 32'hA0FE_0000;
  localparam logic [31:0] RespSelect = 32'h0000_1E00;

  localparam int unsigned IrqCmdDone  = 0;
  localparam int unsigned IrqXferDone = 1;
  localparam int unsigned IrqWriteRdy = 4;
  localparam int unsigned IrqReadRdy  = 5;

  localparam logic [2:0] CardFn1 = 3'd1;

  localparam logic [16:0] CsrWinLo  = 17'h1000A;
  localparam logic [16:0] CsrWinMid = 17'h1000B;
  localparam logic [16:0] CsrWinHi  = 17'h1000C;
  localparam logic [16:0] CsrClock  = 17'h1000E;

  localparam logic [31:0] MapChipId  = 32'h1800_0000;
  localparam logic [31:0] MapCaps    = 32'h1800_0004;
  localparam logic [31:0] MapRomPtr  = 32'h1800_00FC;
  localparam logic [31:0] MapCore    = 32'h1800_0604;
  localparam logic [31:0] MapPmu     = 32'h1800_4000;
  localparam logic [31:0] ValChipId  = 32'h1691_4319;
  localparam logic [31:0] ValCaps    = 32'h1048_0009;
  localparam logic [31:0] RomBase    = 32'h1810_9000;
  localparam logic [31:0] ValCore    = 32'h19CC_3607;
  localparam logic [31:0] ValPmu     = 32'h0025_8033;

  localparam int unsigned ROM_BYTES = 256;

  localparam logic [7:0] ROM_TABLE [ROM_BYTES] = '{
    8'h01, 8'h00, 8'hF8, 8'h4B, 8'h11, 8'h42, 8'h00, 8'h23,
    8'h03, 8'h00, 8'h00, 8'h00, 8'h05, 8'h00, 8'h00, 8'h18,
    8'hC5, 8'h00, 8'h10, 8'h18, 8'h01, 8'h12, 8'hF8, 8'h4B,
    8'h11, 8'h42, 8'h00, 8'h16, 8'h03, 8'h01, 8'h00, 8'h00,
    8'h05, 8'h10, 8'h00, 8'h18, 8'hC5, 8'h10, 8'h10, 8'h18,
    8'h01, 8'h29, 8'hF8, 8'h4B, 8'h11, 8'h42, 8'h00, 8'h03,
    8'h03, 8'h02, 8'h00, 8'h00, 8'h05, 8'h20, 8'h00, 8'h18,
    8'hC5, 8'h20, 8'h10, 8'h18, 8'h01, 8'h2A, 8'hF8, 8'h4B,
    8'h11, 8'h42, 8'h00, 8'h02, 8'h03, 8'h03, 8'h00, 8'h00,
    8'h05, 8'h30, 8'h00, 8'h18, 8'hC5, 8'h30, 8'h10, 8'h18,
    8'h01, 8'h0E, 8'hF8, 8'h4B, 8'h01, 8'h04, 8'h08, 8'h06,
    8'h05, 8'h40, 8'h00, 8'h18, 8'h35, 8'h01, 8'h00, 8'h00,
    8'h00, 8'h80, 8'h04, 8'h00, 8'h35, 8'h01, 8'h00, 8'h10,
    8'h00, 8'h80, 8'h04, 8'h00, 8'h35, 8'h01, 8'h00, 8'h1E,
    8'h00, 8'h00, 8'h02, 8'h00, 8'h85, 8'h41, 8'h10, 8'h18,
    8'h01, 8'h1A, 8'hF8, 8'h4B, 8'h11, 8'h42, 8'h00, 8'h08,
    8'h03, 8'h04, 8'h00, 8'h00, 8'h05, 8'h50, 8'h00, 8'h18,
    8'hC5, 8'h50, 8'h10, 8'h18, 8'h01, 8'h35, 8'hB1, 8'h43,
    8'h01, 8'h02, 8'h08, 8'h00, 8'h75, 8'h00, 8'h00, 8'h18,
    8'h00, 8'h00, 8'h01, 8'h00, 8'h85, 8'h60, 8'h10, 8'h18,
    8'h01, 8'h35, 8'hB1, 8'h43, 8'h01, 8'h02, 8'h08, 8'h00,
    8'h75, 8'h00, 8'h10, 8'h18, 8'h00, 8'h00, 8'h01, 8'h00,
    8'h85, 8'h70, 8'h10, 8'h18, 8'h01, 8'h67, 8'hB3, 8'h43,
    8'h01, 8'h02, 8'h00, 8'h00, 8'h05, 8'h80, 8'h10, 8'h18,
    8'h01, 8'h66, 8'hB3, 8'h43, 8'h01, 8'h02, 8'h00, 8'h00,
    8'h05, 8'h90, 8'h10, 8'h18, 8'h01, 8'h01, 8'hB3, 8'h43,
    8'h01, 8'h02, 8'h00, 8'h11, 8'h05, 8'h60, 8'h00, 8'h18,
    8'h01, 8'hFF, 8'hBF, 8'h43, 8'h01, 8'h02, 8'h08, 8'h00,
    8'h35, 8'h70, 8'h00, 8'h18, 8'h00, 8'h90, 8'h0F, 8'h00,
    8'h35, 8'hB0, 8'h10, 8'h18, 8'h00, 8'h50, 8'hEF, 8'h05,
    8'h35, 8'h40, 8'h01, 8'h1E, 8'h00, 8'hC0, 8'hFE, 8'h01,
    8'h85, 8'hA0, 8'h10, 8'h18, 8'h0F, 8'h00, 8'h00, 8'h00
  };

  function automatic logic [7:0] card_read(logic [2:0] fn, logic [17:0] addr,
                                           logic [16:0] wbase, logic [7:0] csr);
    logic [31:0] a;
    logic [31:0] word;
    logic [7:0]  res;
    a    = {wbase, addr[14:0]};
    word = '0;
    res  = '0;
    if (fn != CardFn1) begin
      res = '0;
    end else if (addr[17:16] == 2'b00) begin
      if (a[31:8] == RomBase[31:8]) begin
        res = ROM_TABLE[a[7:0]];
      end else begin
        unique case ({a[31:2], 2'b00})
          MapChipId: word = ValChipId;
          MapCaps:   word = ValCaps;
          MapRomPtr: word = RomBase;
          MapCore:   word = ValCore;
          MapPmu:    word = ValPmu;
          default:   word = '0;
        endcase
        res = word[{a[1:0], 3'b000} +: 8];
      end
    end else begin
      priority if (addr == {1'b0, CsrWinLo}) begin
        res = {wbase[0], 7'b0};
      end else if (addr == {1'b0, CsrWinMid}) begin
        res = wbase[8:1];
      end else if (addr == {1'b0, CsrWinHi}) begin
        res = wbase[16:9];
      end else if (addr == {1'b0, CsrClock}) begin
        res = csr;
      end else begin
        res = '0;
      end
    end
    return res;
  endfunction

endpackage

### hdl/sdio_wifi_card_register_model.sv
// sdio_wifi_card_register_model: sdio host register file with an attached wifi card
// depends on sdiowf_pkg for request codes, card map, rom and byte read function
// the result of each input transfer is captured in the output register
// throughput: one access per cycle while the output is taken; a buffer read does up to four card byte reads in parallel
// the output register frees the input side whenever the result is taken or absent
// reset: asynchronous, clears all host and card registers (not the output data); the rom is constant
module sdio_wifi_card_register_model (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  req_type_i,
  input  logic [1:0]  resp_index_i,
  input  logic [31:0] write_mask_i,
  input  logic [31:0] write_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] read_data_o
);

  logic [31:0] resp_q [4];
  logic [31:0] resp0_d;
  logic [31:0] arg_q, arg_d;
  logic [5:0]  flags_q, flags_d;
  logic [15:0] enable_q, enable_d;
  logic [15:0] clkctl_q, clkctl_d;
  logic [16:0] wbase_q, wbase_d;
  logic [7:0]  csr_q, csr_d;
  logic [17:0] buf_addr_q, buf_addr_d;
  logic [8:0]  buf_rem_q, buf_rem_d;
  logic [2:0]  buf_fn_q, buf_fn_d;
  logic        out_valid_q;
  logic [31:0] rdata_q, rdata_d;

  logic        in_fire;
  logic        is_write;
  logic [15:0] m16, v16, mv16;
  logic [5:0]  cmd;
  logic [2:0]  take;
  logic [31:0] buf_word;
  logic [7:0]  direct_byte;
  logic [5:0]  raise;
  logic [15:0] cc_tmp;
  logic [7:0]  csr_tmp;

  assign in_fire     = in_valid_i && in_ready_o;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign read_data_o = rdata_q;
  assign is_write    = req_type_i >= sdiowf_pkg::ReqWriteArgs;

  assign m16  = write_mask_i[15:0];
  assign v16  = write_value_i[15:0];
  assign mv16 = m16 & v16;
  assign cmd  = mv16[13:8];

  // buffer port lanes
  assign take = (buf_rem_q < 9'd4) ? buf_rem_q[2:0] : 3'd4;
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (3'(i) < take) begin
        buf_word[i*8 +: 8] = sdiowf_pkg::card_read(buf_fn_q, buf_addr_q + 18'(i),
                                                   wbase_q, csr_q);
      end else begin
        buf_word[i*8 +: 8] = '0;
      end
    end
  end

  assign direct_byte = sdiowf_pkg::card_read(arg_q[30:28], {1'b0, arg_q[25:9]},
                                             wbase_q, csr_q);

  always_comb begin
    resp0_d    = resp_q[0];
    arg_d      = arg_q;
    enable_d   = enable_q;
    clkctl_d   = clkctl_q;
    wbase_d    = wbase_q;
    csr_d      = csr_q;
    buf_addr_d = buf_addr_q;
    buf_rem_d  = buf_rem_q;
    buf_fn_d   = buf_fn_q;
    rdata_d    = '0;
    raise      = '0;
    cc_tmp     = '0;
    csr_tmp    = '0;
    unique case (sdiowf_pkg::req_e'(req_type_i))
      sdiowf_pkg::ReqReadResp:   rdata_d = resp_q[resp_index_i];
      sdiowf_pkg::ReqReadBuffer: begin
        rdata_d    = buf_word;
        buf_rem_d  = buf_rem_q - {6'b0, take};
        buf_addr_d = buf_addr_q + {15'b0, take};
        if (buf_rem_d == '0) begin
          raise[sdiowf_pkg::IrqXferDone] = 1'b1;
        end
      end
      sdiowf_pkg::ReqReadClkCtl: rdata_d = {16'b0, clkctl_q};
      sdiowf_pkg::ReqReadFlags:  rdata_d = {26'b0, flags_q};
      sdiowf_pkg::ReqReadEnable: rdata_d = {16'b0, enable_q};
      sdiowf_pkg::ReqWriteArgs:  arg_d = (arg_q & ~write_mask_i) | (write_value_i & write_mask_i);
      sdiowf_pkg::ReqWriteCmd: begin
        raise[sdiowf_pkg::IrqCmdDone] = 1'b1;
        unique case (cmd)
          sdiowf_pkg::CmdIoSendOpCond: resp0_d = sdiowf_pkg::RespOpCond;
          sdiowf_pkg::CmdSelect:       resp0_d = sdiowf_pkg::RespSelect;
          sdiowf_pkg::CmdIoRwDirect: begin
            if (arg_q[31]) begin
              resp0_d = '0;
              if (arg_q[30:28] == sdiowf_pkg::CardFn1) begin
                priority if (arg_q[25:9] == sdiowf_pkg::CsrWinLo) begin
                  wbase_d[0] = arg_q[7];
                end else if (arg_q[25:9] == sdiowf_pkg::CsrWinMid) begin
                  wbase_d[8:1] = arg_q[7:0];
                end else if (arg_q[25:9] == sdiowf_pkg::CsrWinHi) begin
                  wbase_d[16:9] = arg_q[7:0];
                end else if (arg_q[25:9] == sdiowf_pkg::CsrClock) begin
                  csr_tmp = {csr_q[7:6], arg_q[5:0]};
                  csr_d   = {csr_tmp[7:6] | csr_tmp[4:3], csr_tmp[5:0]};
                end else begin
                  csr_d = csr_q;
                end
              end
            end else begin
              resp0_d = {24'b0, direct_byte};
            end
          end
          sdiowf_pkg::CmdIoRwExtended: begin
            buf_addr_d = {1'b0, arg_q[25:9]};
            buf_rem_d  = arg_q[8:0];
            buf_fn_d   = arg_q[30:28];
            resp0_d    = '0;
            if (arg_q[31]) begin
              raise[sdiowf_pkg::IrqWriteRdy] = 1'b1;
            end else begin
              raise[sdiowf_pkg::IrqReadRdy] = 1'b1;
            end
          end
          default: resp0_d = resp_q[0];
        endcase
      end
      sdiowf_pkg::ReqWriteClk: begin
        cc_tmp   = (clkctl_q & ~m16) | mv16;
        clkctl_d = {cc_tmp[15:2], cc_tmp[1] | cc_tmp[0], cc_tmp[0]};
      end
      sdiowf_pkg::ReqClearFlags: rdata_d = '0;
      sdiowf_pkg::ReqWriteEn:    enable_d = (enable_q & ~m16) | mv16;
      default:                   rdata_d = '0;
    endcase
  end

  always_comb begin
    flags_d = flags_q | (raise & enable_q[5:0]);
    if (sdiowf_pkg::req_e'(req_type_i) == sdiowf_pkg::ReqClearFlags) begin
      flags_d = flags_q & ~mv16[5:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        resp_q[i] <= '0;
      end
      arg_q      <= '0;
      flags_q    <= '0;
      enable_q   <= '0;
      clkctl_q   <= '0;
      wbase_q    <= '0;
      csr_q      <= '0;
      buf_addr_q <= '0;
      buf_rem_q  <= '0;
      buf_fn_q   <= '0;
    end else if (in_fire) begin
      resp_q[0]  <= resp0_d;
      arg_q      <= arg_d;
      flags_q    <= flags_d;
      enable_q   <= enable_d;
      clkctl_q   <= clkctl_d;
      wbase_q    <= wbase_d;
      csr_q      <= csr_d;
      buf_addr_q <= buf_addr_d;
      buf_rem_q  <= buf_rem_d;
      buf_fn_q   <= buf_fn_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rdata_q <= rdata_d;
    end
  end

  a_write_reads_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && is_write) |=> (read_data_o == '0))
    else $error("write transfer returned non-zero data");

  a_flag_needs_enable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> ((flags_q & ~$past(flags_q) & ~$past(enable_q[5:0])) == '0))
    else $error("interrupt flag set while disabled");

  a_buffer_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && sdiowf_pkg::req_e'(req_type_i) == sdiowf_pkg::ReqReadBuffer)
    |=> (buf_rem_q <= $past(buf_rem_q)))
    else $error("buffer remaining count grew on a buffer read");

  a_idle_holds_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_fire |=> ($stable(flags_q) && $stable(buf_rem_q) && $stable(arg_q)))
    else $error("state changed without an input transfer");

endmodule
